FILE: rtl/vdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdp_pkg
// Shared types, phase codes and helpers for the VP8 payload descriptor parser.
// ----------------------------------------------------------------------------
package vdp_pkg;

  localparam int unsigned PhaseW = 3;

  // parse phases
  localparam logic [PhaseW-1:0] PH_FIRST  = 3'd0;
  localparam logic [PhaseW-1:0] PH_EXT    = 3'd1;
  localparam logic [PhaseW-1:0] PH_PIC_HI = 3'd2;
  localparam logic [PhaseW-1:0] PH_PIC_LO = 3'd3;
  localparam logic [PhaseW-1:0] PH_TL0    = 3'd4;
  localparam logic [PhaseW-1:0] PH_TK     = 3'd5;
  localparam logic [PhaseW-1:0] PH_DONE   = 3'd6;

  // extension byte selection bits (after shifting the byte down by four)
  localparam int unsigned ExtI = 3;
  localparam int unsigned ExtL = 2;
  localparam int unsigned ExtT = 1;
  localparam int unsigned ExtK = 0;

  localparam logic [2:0] CountMax = 3'd7;

  typedef struct packed {
    logic        start_of_partition;
    logic [3:0]  partition_index;
    logic        picture_present;
    logic [14:0] picture_number;
    logic        base_index_present;
    logic [7:0]  base_layer_index;
    logic        temporal_present;
    logic [1:0]  temporal_layer;
    logic        layer_sync;
    logic        key_present;
    logic [4:0]  key_index;
  } fields_t;

  typedef struct packed {
    fields_t    fields;
    logic [2:0] consumed_bytes;
  } result_t;

  // next phase after the given one, by the I, L and T|K selections
  function automatic logic [PhaseW-1:0] next_phase(input logic [PhaseW-1:0] after,
                                                   input logic [3:0] flags);
    logic [PhaseW-1:0] nxt;
    nxt = PH_DONE;
    if (after < PH_PIC_HI && flags[ExtI]) begin
      nxt = PH_PIC_HI;
    end else if (after < PH_TL0 && flags[ExtL]) begin
      nxt = PH_TL0;
    end else if (after < PH_TK && (flags[ExtT] || flags[ExtK])) begin
      nxt = PH_TK;
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/vp8_descriptor_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8_descriptor_parser_top
// VP8 RTP payload descriptor parser, one payload byte per beat.
// ----------------------------------------------------------------------------
// Accepts one payload byte every clock while in_stall_o is low. A result beat
// is produced for the byte that completes the descriptor (consumed_bytes 1 to
// 6) or for a last byte that ends the packet early (consumed_bytes 0); it is
// registered in the output buffer before it appears on the output. Each byte
// goes through a single phase update; a two-entry output register absorbs
// downstream stall, and in_stall_o rises only when both entries hold results.
module vp8_descriptor_parser_top import vdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        start_of_partition_o,
  output logic [3:0]  partition_index_o,
  output logic        picture_present_o,
  output logic [14:0] picture_number_o,
  output logic        base_index_present_o,
  output logic [7:0]  base_layer_index_o,
  output logic        temporal_present_o,
  output logic [1:0]  temporal_layer_o,
  output logic        layer_sync_o,
  output logic        key_present_o,
  output logic [4:0]  key_index_o,
  output logic [2:0]  consumed_bytes_o
);

  logic    beat;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t out;

  assign in_stall_o = full;
  assign beat       = in_valid_i && !full;

  vdp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vdp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out)
  );

  assign start_of_partition_o = out.fields.start_of_partition;
  assign partition_index_o    = out.fields.partition_index;
  assign picture_present_o    = out.fields.picture_present;
  assign picture_number_o     = out.fields.picture_number;
  assign base_index_present_o = out.fields.base_index_present;
  assign base_layer_index_o   = out.fields.base_layer_index;
  assign temporal_present_o   = out.fields.temporal_present;
  assign temporal_layer_o     = out.fields.temporal_layer;
  assign layer_sync_o         = out.fields.layer_sync;
  assign key_present_o        = out.fields.key_present;
  assign key_index_o          = out.fields.key_index;
  assign consumed_bytes_o     = out.consumed_bytes;

endmodule

FILE: rtl/vdp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdp_parse
// Descriptor phase tracker: updates the parse state for one payload byte and
// flags a result when the descriptor completes or the packet ends early.
// ----------------------------------------------------------------------------
module vdp_parse import vdp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [3:0]        flags_q, flags_d;
  logic [2:0]        count_q, count_d;
  logic [6:0]        pic_hi_q, pic_hi_d;
  fields_t           fields_q, fields_d;
  logic              skip_q, skip_d;

  always_comb begin
    logic [PhaseW-1:0] ph;
    phase_d     = phase_q;
    flags_d     = flags_q;
    count_d     = count_q;
    pic_hi_d    = pic_hi_q;
    fields_d    = fields_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    ph          = phase_q;

    if (beat_i) begin
      if (skip_q) begin
        // trailing payload after a complete descriptor
        if (last_byte_i) begin
          skip_d  = 1'b0;
          phase_d = PH_FIRST;
        end
      end else begin
        if (count_q < CountMax) begin
          count_d = count_q + 3'd1;
        end
        unique case (phase_q)
          PH_EXT: begin
            flags_d = data_byte_i[7:4];
            ph      = next_phase(PH_EXT, data_byte_i[7:4]);
          end
          PH_PIC_HI: begin
            if (data_byte_i[7]) begin
              pic_hi_d = data_byte_i[6:0];
              ph       = PH_PIC_LO;
            end else begin
              fields_d.picture_number  = {7'd0, data_byte_i};
              fields_d.picture_present = 1'b1;
              ph                       = next_phase(PH_PIC_LO, flags_q);
            end
          end
          PH_PIC_LO: begin
            fields_d.picture_number  = {pic_hi_q, data_byte_i};
            fields_d.picture_present = 1'b1;
            ph                       = next_phase(PH_PIC_LO, flags_q);
          end
          PH_TL0: begin
            fields_d.base_layer_index   = data_byte_i;
            fields_d.base_index_present = 1'b1;
            ph                          = next_phase(PH_TL0, flags_q);
          end
          PH_TK: begin
            if (flags_q[ExtT]) begin
              fields_d.temporal_layer   = data_byte_i[7:6];
              fields_d.layer_sync       = data_byte_i[5];
              fields_d.temporal_present = 1'b1;
            end
            if (flags_q[ExtK]) begin
              fields_d.key_index   = data_byte_i[4:0];
              fields_d.key_present = 1'b1;
            end
            ph = PH_DONE;
          end
          default: begin
            // first descriptor byte starts a fresh packet
            fields_d                    = '0;
            flags_d                     = '0;
            pic_hi_d                    = '0;
            count_d                     = 3'd1;
            fields_d.start_of_partition = data_byte_i[4];
            fields_d.partition_index    = data_byte_i[3:0];
            ph                          = data_byte_i[7] ? PH_EXT : PH_DONE;
          end
        endcase

        phase_d = ph;
        if (ph == PH_DONE) begin
          res_valid_o          = 1'b1;
          res_o.fields         = fields_d;
          res_o.consumed_bytes = count_d;
          phase_d              = PH_FIRST;
          skip_d               = !last_byte_i;
        end else if (last_byte_i) begin
          // truncated descriptor
          res_valid_o          = 1'b1;
          res_o.fields         = fields_d;
          res_o.consumed_bytes = 3'd0;
          phase_d              = PH_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      flags_q  <= '0;
      count_q  <= '0;
      pic_hi_q <= '0;
      fields_q <= '0;
      skip_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      count_q  <= count_d;
      pic_hi_q <= pic_hi_d;
      fields_q <= fields_d;
      skip_q   <= skip_d;
    end
  end

endmodule

FILE: rtl/vdp_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdp_outbuf
// Result register with a skid stage, so the input side keeps running while a
// finished result waits downstream.
// ----------------------------------------------------------------------------
module vdp_outbuf import vdp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // no push can arrive while the skid stage is occupied
      if (take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/vdp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdp_checker
// Port-level checks for the VP8 descriptor parser, bound to the top level.
// ----------------------------------------------------------------------------
module vdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        start_of_partition_o,
  input logic [3:0]  partition_index_o,
  input logic        picture_present_o,
  input logic [14:0] picture_number_o,
  input logic        base_index_present_o,
  input logic        temporal_present_o,
  input logic [1:0]  temporal_layer_o,
  input logic        layer_sync_o,
  input logic        key_present_o,
  input logic [4:0]  key_index_o,
  input logic [2:0]  consumed_bytes_o
);

  // a descriptor is never longer than six bytes
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> consumed_bytes_o != 3'd7)
    else $error("consumed_bytes out of range");

  // a one-byte descriptor has no extension fields
  a_short_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && consumed_bytes_o == 3'd1) |->
      (!picture_present_o && !base_index_present_o && !temporal_present_o && !key_present_o))
    else $error("extension field reported on a one-byte descriptor");

  // picture number, key index and temporal fields that were not parsed read as zero
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((picture_present_o || picture_number_o == '0) &&
       (key_present_o || key_index_o == '0) &&
       (temporal_present_o || (temporal_layer_o == '0 && !layer_sync_o))))
    else $error("absent field carries a value");

  // the extension byte itself counts, so any field means at least three bytes
  a_ext_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && consumed_bytes_o != 3'd0 &&
     (picture_present_o || base_index_present_o || temporal_present_o || key_present_o))
      |-> consumed_bytes_o >= 3'd3)
    else $error("extension field with too short a descriptor");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(consumed_bytes_o) && $stable(partition_index_o) &&
       $stable(start_of_partition_o) && $stable(picture_number_o)))
    else $error("stalled result beat changed");

endmodule

bind vp8_descriptor_parser_top vdp_checker u_vdp_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .start_of_partition_o (start_of_partition_o),
  .partition_index_o    (partition_index_o),
  .picture_present_o    (picture_present_o),
  .picture_number_o     (picture_number_o),
  .base_index_present_o (base_index_present_o),
  .temporal_present_o   (temporal_present_o),
  .temporal_layer_o     (temporal_layer_o),
  .layer_sync_o         (layer_sync_o),
  .key_present_o        (key_present_o),
  .key_index_o          (key_index_o),
  .consumed_bytes_o     (consumed_bytes_o)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the VP8 payload descriptor parser: directed packets
// for the edge cases, then random well-formed, truncated and noisy packets,
// with both sides stalling in bursts and every result checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import vdp_pkg::*;

  localparam int RandomBytes = 1700;
  localparam int TailBytes   = 250;   // no idling once this few remain
  localparam int HoldAfter   = 40;    // results seen before the long hold-off
  localparam int LongHold    = 120;
  localparam int SettleCycles = 10;
  localparam int WatchLimit  = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;   // wait for all results before offering this beat
  } payload_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        start_of_partition_o;
  logic [3:0]  partition_index_o;
  logic        picture_present_o;
  logic [14:0] picture_number_o;
  logic        base_index_present_o;
  logic [7:0]  base_layer_index_o;
  logic        temporal_present_o;
  logic [1:0]  temporal_layer_o;
  logic        layer_sync_o;
  logic        key_present_o;
  logic [4:0]  key_index_o;
  logic [2:0]  consumed_bytes_o;

  payload_beat_t payload_beats[$];
  result_t       pending_descriptors[$];
  payload_beat_t next_beat;
  result_t       want;

  int  bytes_total = 0;
  int  bytes_taken = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  bit  drain_next = 1'b0;
  bit  quiet_tail = 1'b0;

  // parser shadow state
  logic [2:0] shadow_phase = PH_FIRST;
  logic [3:0] shadow_sel = '0;
  logic [2:0] shadow_count = '0;
  logic [6:0] shadow_pic_hi = '0;
  fields_t    shadow_fields = '0;
  bit         shadow_skip = 1'b0;

  always #2 clk_i = ~clk_i;

  vp8_descriptor_parser_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte),
    .last_byte_i         (last_byte),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .start_of_partition_o(start_of_partition_o),
    .partition_index_o   (partition_index_o),
    .picture_present_o   (picture_present_o),
    .picture_number_o    (picture_number_o),
    .base_index_present_o(base_index_present_o),
    .base_layer_index_o  (base_layer_index_o),
    .temporal_present_o  (temporal_present_o),
    .temporal_layer_o    (temporal_layer_o),
    .layer_sync_o        (layer_sync_o),
    .key_present_o       (key_present_o),
    .key_index_o         (key_index_o),
    .consumed_bytes_o    (consumed_bytes_o)
  );

  // field that follows the given phase under the current I, L, T|K selection
  function automatic logic [2:0] phase_after(input logic [2:0] from);
    logic [2:0] p;
    p = PH_DONE;
    if (from < PH_TK && (shadow_sel[ExtT] || shadow_sel[ExtK])) p = PH_TK;
    if (from < PH_TL0 && shadow_sel[ExtL]) p = PH_TL0;
    if (from < PH_PIC_HI && shadow_sel[ExtI]) p = PH_PIC_HI;
    return p;
  endfunction

  function automatic void parse_descriptor_byte(input logic [7:0] b, input logic lastb);
    if (shadow_skip) begin
      if (lastb) begin
        shadow_skip = 1'b0;
        shadow_phase = PH_FIRST;
      end
      return;
    end
    if (shadow_count < CountMax) shadow_count = shadow_count + 3'd1;
    case (shadow_phase)
      PH_EXT: begin
        shadow_sel = b[7:4];
        shadow_phase = phase_after(PH_EXT);
      end
      PH_PIC_HI: begin
        if (b[7]) begin
          shadow_pic_hi = b[6:0];
          shadow_phase = PH_PIC_LO;
        end else begin
          shadow_fields.picture_number = {7'd0, b};
          shadow_fields.picture_present = 1'b1;
          shadow_phase = phase_after(PH_PIC_LO);
        end
      end
      PH_PIC_LO: begin
        shadow_fields.picture_number = {shadow_pic_hi, b};
        shadow_fields.picture_present = 1'b1;
        shadow_phase = phase_after(PH_PIC_LO);
      end
      PH_TL0: begin
        shadow_fields.base_layer_index = b;
        shadow_fields.base_index_present = 1'b1;
        shadow_phase = phase_after(PH_TL0);
      end
      PH_TK: begin
        if (shadow_sel[ExtT]) begin
          shadow_fields.temporal_layer = b[7:6];
          shadow_fields.layer_sync = b[5];
          shadow_fields.temporal_present = 1'b1;
        end
        if (shadow_sel[ExtK]) begin
          shadow_fields.key_index = b[4:0];
          shadow_fields.key_present = 1'b1;
        end
        shadow_phase = PH_DONE;
      end
      default: begin
        shadow_fields = '0;
        shadow_sel = '0;
        shadow_pic_hi = '0;
        shadow_count = 3'd1;
        shadow_fields.start_of_partition = b[4];
        shadow_fields.partition_index = b[3:0];
        shadow_phase = b[7] ? PH_EXT : PH_DONE;
      end
    endcase
    if (shadow_phase == PH_DONE) begin
      pending_descriptors.insert(pending_descriptors.size(), {shadow_fields, shadow_count});
      shadow_phase = PH_FIRST;
      shadow_skip = !lastb;
    end else if (lastb) begin
      // packet ended before the descriptor did
      pending_descriptors.insert(pending_descriptors.size(), {shadow_fields, 3'd0});
      shadow_phase = PH_FIRST;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic push_beat(input logic [7:0] d, input logic l);
    payload_beats.insert(payload_beats.size(), {d, l, drain_next});
    drain_next = 1'b0;
    bytes_total++;
  endtask

  // one packet: mostly a well-formed descriptor plus trailing bytes, some cut short,
  // some pure noise; returns the number of bytes that count as real work
  task automatic add_random_packet(output int worth);
    logic [7:0] pkt [0:15];
    logic [7:0] ext;
    int n;
    int full;
    int pick;
    n = 0;
    pick = $urandom_range(99);
    if (pick < 12) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        push_beat(8'($urandom), (i == n - 1) || ($urandom_range(99) < 25));
      end
      worth = n;
      return;
    end
    pkt[n] = {($urandom_range(99) < 85), 7'($urandom)}; n = n + 1;
    if (pkt[0][7]) begin
      ext = 8'($urandom);
      pkt[n] = ext; n = n + 1;
      if (ext[7]) begin
        if ($urandom_range(1)) begin
          pkt[n] = {1'b1, 7'($urandom)}; n = n + 1;
          pkt[n] = 8'($urandom); n = n + 1;
        end else begin
          pkt[n] = {1'b0, 7'($urandom)}; n = n + 1;
        end
      end
      if (ext[6]) begin
        pkt[n] = 8'($urandom); n = n + 1;
      end
      if (ext[5] || ext[4]) begin
        pkt[n] = 8'($urandom); n = n + 1;
      end
    end
    full = n;
    for (int i = $urandom_range(0, 3); i > 0; i--) begin
      pkt[n] = 8'($urandom); n = n + 1;
    end
    if (full > 1 && pick >= 85) n = $urandom_range(1, full - 1);
    for (int i = 0; i < n; i++) push_beat(pkt[i], i == n - 1);
    worth = (n < full) ? n : full;
  endtask

  // sender
  int unsigned gap_left = 0;
  int unsigned send_window = 0;
  int unsigned send_idle_pct = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      data_byte <= '0;
      last_byte <= 1'b0;
      quiet_tail <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        parse_descriptor_byte(data_byte, last_byte);
        bytes_taken++;
      end
      quiet_tail <= payload_beats.size() < TailBytes;
      if (send_window == 0) begin
        send_window = $urandom_range(16, 96);
        case ($urandom_range(2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          default: send_idle_pct = 40;
        endcase
      end else begin
        send_window--;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (payload_beats.size() == 0) begin
          in_valid <= 1'b0;
        end else if (payload_beats[0].drain && pending_descriptors.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(99) < send_idle_pct) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          next_beat = payload_beats.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_beat.data;
          last_byte <= next_beat.last;
        end
      end
    end
  end

  // receiver and checker
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;
  int unsigned recv_window = 0;
  int unsigned recv_stall_pct = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (pending_descriptors.size() == 0) begin
          $error("result beat arrived with nothing expected");
          mismatches++;
        end else begin
          want = pending_descriptors.pop_front();
          check_field("start_of_partition", want.fields.start_of_partition,
                      start_of_partition_o);
          check_field("partition_index", want.fields.partition_index, partition_index_o);
          check_field("picture_present", want.fields.picture_present, picture_present_o);
          check_field("picture_number", want.fields.picture_number, picture_number_o);
          check_field("base_index_present", want.fields.base_index_present,
                      base_index_present_o);
          check_field("base_layer_index", want.fields.base_layer_index, base_layer_index_o);
          check_field("temporal_present", want.fields.temporal_present, temporal_present_o);
          check_field("temporal_layer", want.fields.temporal_layer, temporal_layer_o);
          check_field("layer_sync", want.fields.layer_sync, layer_sync_o);
          check_field("key_present", want.fields.key_present, key_present_o);
          check_field("key_index", want.fields.key_index, key_index_o);
          check_field("consumed_bytes", want.consumed_bytes, consumed_bytes_o);
        end
      end
      if (recv_window == 0) begin
        recv_window = $urandom_range(16, 96);
        case ($urandom_range(2))
          0: recv_stall_pct = 0;
          1: recv_stall_pct = 15;
          default: recv_stall_pct = 40;
        endcase
      end else begin
        recv_window--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && results_seen >= HoldAfter) begin
        // long hold-off so the output buffer fills and backs up the input
        held_once = 1'b1;
        hold_left = LongHold - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(99) < recv_stall_pct) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no beat moving on either side
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == WatchLimit) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    int counted;
    int worth;
    int next_drain;
    counted = 0;
    next_drain = 500;

    // no extension, complete on its last byte
    push_beat(8'h00, 1'b1);
    // reserved and N bits set, S set, partition 15
    push_beat(8'h7F, 1'b1);
    // empty extension, low nibble ignored, T and K clear
    push_beat(8'h80, 1'b0);
    push_beat(8'h0F, 1'b1);
    // everything present with a 15-bit picture id, then trailing payload
    push_beat(8'h90, 1'b0);
    push_beat(8'hF0, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hAA, 1'b1);
    // truncated right after the first byte
    push_beat(8'h80, 1'b1);
    // truncated between the two picture id bytes
    push_beat(8'h80, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h80, 1'b1);
    // 7-bit picture id only, then one trailing byte
    push_beat(8'h80, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h7F, 1'b0);
    push_beat(8'h00, 1'b1);
    // temporal id only
    push_beat(8'h80, 1'b0);
    push_beat(8'h20, 1'b0);
    push_beat(8'hE0, 1'b1);
    // tl0 index and key index selected, but the packet ends before the key index byte
    push_beat(8'h80, 1'b0);
    push_beat(8'h50, 1'b0);
    push_beat(8'h55, 1'b1);

    while (bytes_total < RandomBytes) begin
      if (counted >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 600;
      end
      add_random_packet(worth);
      counted += worth;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != bytes_total || pending_descriptors.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
